>>> design/aprd_pkg.sv
// shared types and constants for the audio peak / rms decimator
package aprd_pkg;

	localparam int WINDOW_DEPTH = 4096;
	localparam int MAX_RATIO = 4096;
	localparam int NUM_REGS = 5;
	localparam int CFG_WIDTH = 13;
	localparam int CFG_IDX_WIDTH = 3;
	localparam int SAMPLE_W = 16;
	localparam int MAG_W = 16;
	localparam int FRAME_W = 48;
	localparam int IN_WIDTH = 128;
	localparam int OUT_WIDTH = 136;
	localparam int SUM_W = 43;
	localparam int DEC_SUM_W = 28;
	localparam int QUOT_W = 43;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_NUM_CHANNELS = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_DECIMATION_RATIO = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_RMS_WINDOW_LENGTH = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_PEAK_ENABLE = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_RMS_ENABLE = 3'd4;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIV,
		ST_SQRT,
		ST_MEAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [MAG_W-1:0]   max_amplitude;
		logic [MAG_W-1:0]   rms_level;
		logic               point_valid;
		logic [MAG_W-1:0]   point_mean;
		logic [MAG_W-1:0]   point_peak;
		logic [MAG_W-1:0]   point_rms;
		logic [FRAME_W-1:0] frames_seen;
	} result_t;

	typedef struct packed {
		logic            start;
		logic [QUOT_W-1:0] dividend;
		logic [15:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [QUOT_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> design/aprd_divider.sv
// restoring divider, one quotient bit per cycle
module aprd_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  aprd_pkg::div_req_t req,
	output aprd_pkg::div_rsp_t rsp
);
	import aprd_pkg::*;

	logic [QUOT_W-1:0] quot_q;
	logic [16:0]       rem_q;
	logic [15:0]       dvs_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [16:0]       trial;
	logic [17:0]       diff;

	always_comb begin
		trial = {rem_q[15:0], quot_q[QUOT_W-1]};
		diff = {1'b0, trial} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(QUOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q <= diff[16:0];
				quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quot_q;

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

	property p_no_start_busy;
		@(posedge clk) disable iff (!arst_n) busy_q |-> !req.start;
	endproperty
	a_no_start_busy: assert property (p_no_start_busy) else $error("start while busy");

	property p_done_pulse;
		@(posedge clk) disable iff (!arst_n) done_q |=> !done_q;
	endproperty
	a_done_pulse: assert property (p_done_pulse) else $error("done held");

endmodule

>>> design/audio_peak_rms_decimator.sv
// top level of the audio peak / rms decimating envelope
// A frame's time from its acceptance until the next frame can be taken is set by the
// bit-serial divider (sum / window length, and again for the point mean when it completes a
// point), a 21-step square root and the read-modify-write of the window memory; with rms
// disabled a frame skips the first division, the square root and the memory write. A finished word
// waits in one output register while the next frame is processed; a frame stalls before
// leaving only while the previous word has not been taken. After reset the window memory is
// swept clear, one entry a cycle, and the same sweep follows every write of
// rms_window_length; no frame is taken meanwhile.
module audio_peak_rms_decimator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [aprd_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [aprd_pkg::CFG_WIDTH-1:0]     cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// ch0_sample .. ch7_sample, 16 bits each
	input  logic [aprd_pkg::IN_WIDTH-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// max_amplitude, rms_level, point_valid, point_mean, point_peak, point_rms,
	// frames_seen, 7 zero pad bits
	output logic [aprd_pkg::OUT_WIDTH-1:0]     m_tdata
);
	import aprd_pkg::*;

	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	state_t state_q, state_d;

	logic [3:0]  nch_q;
	logic [12:0] ratio_q;
	logic [12:0] wlen_q;
	logic        peak_en_q;
	logic        rms_en_q;

	logic [MAG_W-1:0] mem [WINDOW_DEPTH];
	logic [MAG_W-1:0] rd_q;
	logic [AW-1:0]    clr_ptr_q;
	logic [AW-1:0]    pos_q;
	logic             clr_req_q;

	logic [SUM_W-1:0]     sqsum_q;
	logic [DEC_SUM_W-1:0] dsum_q;
	logic [MAG_W-1:0]     dpeak_q;
	logic [12:0]          dcount_q;
	logic [MAG_W-1:0]     rmax_q;
	logic [MAG_W-1:0]     rms_q;
	logic [FRAME_W-1:0]   frames_q;
	logic [MAG_W-1:0]     mag_q;
	logic                 point_q;
	logic [MAG_W-1:0]     pmean_q;

	logic [SUM_W-1:0] sq_x_q;
	logic [SUM_W-1:0] sq_r_q;
	logic [4:0]       sq_cnt_q;

	logic              out_valid_q;
	logic              out_go;
	result_t           out_q;
	div_req_t          dreq;
	div_rsp_t          drsp;
	logic              div_for_mean_q;

	logic [3:0]  n_eff;
	logic [12:0] ratio_eff;
	logic [12:0] len_eff;
	logic signed [19:0] acc;
	logic signed [19:0] mono;
	logic [19:0]        absacc;
	logic [19:0]        absq;
	logic [MAG_W-1:0]   mag_c;
	logic [AW-1:0]      pos_use;
	logic [31:0]        old_sq;
	logic [31:0]        new_sq;
	logic [12:0]        dcount_n;
	logic [DEC_SUM_W-1:0] dsum_n;
	logic [MAG_W-1:0]   dpeak_n;
	logic [SUM_W-1:0]   sq_bit;
	logic [SUM_W-1:0]   sq_rb;
	logic               in_acc;

	always_comb begin
		n_eff = (nch_q == 4'd0) ? 4'd1 : ((nch_q > 4'd8) ? 4'd8 : nch_q);
		ratio_eff = (ratio_q == 13'd0) ? 13'd1 :
			((ratio_q > 13'(MAX_RATIO)) ? 13'(MAX_RATIO) : ratio_q);
		len_eff = (wlen_q == 13'd0) ? 13'd1 :
			((wlen_q > 13'(WINDOW_DEPTH)) ? 13'(WINDOW_DEPTH) : wlen_q);
	end

	// mono sum, then divide its magnitude by channel count through shifts or reciprocal multiplication
	always_comb begin
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n_eff)
				acc = acc + 20'(signed'(s_tdata[i*SAMPLE_W +: SAMPLE_W]));
		end
		absacc = acc[19] ? 20'(-acc) : acc;
		unique case (n_eff)
			4'd1: absq = absacc;
			4'd2: absq = absacc >> 1;
			4'd4: absq = absacc >> 2;
			4'd8: absq = absacc >> 3;
			4'd3: absq = 20'((40'(absacc) * 40'd43691) >> 17);
			4'd5: absq = 20'((40'(absacc) * 40'd52429) >> 18);
			4'd6: absq = 20'((40'(absacc >> 1) * 40'd43691) >> 17);
			4'd7: absq = 20'((40'(absacc) * 40'd299594) >> 21);
			default: absq = absacc;
		endcase
		mono = signed'(absq);
		mag_c = mono[MAG_W-1:0];
	end

	assign in_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && !clr_req_q;
	assign out_go = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	always_comb begin
		pos_use = (32'(pos_q) < 32'(len_eff)) ? pos_q : '0;
		old_sq = 32'(rd_q) * 32'(rd_q);
		new_sq = 32'(mag_q) * 32'(mag_q);
		dcount_n = dcount_q + 13'd1;
		dsum_n = dsum_q + DEC_SUM_W'(mag_q);
		dpeak_n = (mag_q > dpeak_q) ? mag_q : dpeak_q;
		sq_bit = SUM_W'(1) << {sq_cnt_q, 1'b0};
		sq_rb = sq_r_q + sq_bit;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (32'(clr_ptr_q) == WINDOW_DEPTH - 1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (clr_req_q) state_d = ST_CLEAR;
				else if (in_acc) state_d = ST_READ;
			end
			ST_READ: state_d = ST_UPDATE;
			ST_UPDATE: state_d = rms_en_q ? ST_DIV : ST_MEAN;
			ST_DIV: if (drsp.done) state_d = ST_SQRT;
			ST_SQRT: if (sq_cnt_q == 5'd0) state_d = ST_MEAN;
			ST_MEAN: begin
				if (!point_q || (div_for_mean_q && drsp.done)) state_d = ST_OUT;
			end
			ST_OUT: if (out_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = '0;
		dreq.divisor = '0;
		if (state_q == ST_UPDATE && rms_en_q) begin
			dreq.start = 1'b1;
			dreq.dividend = sqsum_q - SUM_W'(old_sq) + SUM_W'(new_sq);
			dreq.divisor = 16'(len_eff);
		end else if (state_q == ST_MEAN && point_q && !div_for_mean_q) begin
			dreq.start = 1'b1;
			dreq.dividend = QUOT_W'(dsum_q);
			dreq.divisor = 16'(dcount_q);
		end
	end

	aprd_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR)
			mem[clr_ptr_q] <= '0;
		else if (state_q == ST_UPDATE && rms_en_q)
			mem[pos_use] <= mag_q;
		rd_q <= mem[pos_use];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			nch_q <= 4'd1;
			ratio_q <= 13'd64;
			wlen_q <= 13'd1024;
			peak_en_q <= 1'b1;
			rms_en_q <= 1'b1;
			clr_ptr_q <= '0;
			clr_req_q <= 1'b0;
			pos_q <= '0;
			sqsum_q <= '0;
			dsum_q <= '0;
			dpeak_q <= '0;
			dcount_q <= '0;
			rmax_q <= '0;
			rms_q <= '0;
			frames_q <= '0;
			out_valid_q <= 1'b0;
			point_q <= 1'b0;
			div_for_mean_q <= 1'b0;
			sq_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_ptr_q <= clr_ptr_q + AW'(1);
			else clr_ptr_q <= '0;
			if (state_q == ST_IDLE && clr_req_q) clr_req_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NUM_CHANNELS: nch_q <= cfg_data[3:0];
					REG_DECIMATION_RATIO: begin
						ratio_q <= cfg_data;
						dsum_q <= '0;
						dpeak_q <= '0;
						dcount_q <= '0;
					end
					REG_RMS_WINDOW_LENGTH: begin
						wlen_q <= cfg_data;
						sqsum_q <= '0;
						pos_q <= '0;
						clr_req_q <= 1'b1;
					end
					REG_PEAK_ENABLE: peak_en_q <= cfg_data[0];
					REG_RMS_ENABLE: rms_en_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_UPDATE: begin
					if (mag_q > rmax_q) rmax_q <= mag_q;
					if (frames_q != '1) frames_q <= frames_q + FRAME_W'(1);
					if (rms_en_q) begin
						sqsum_q <= sqsum_q - SUM_W'(old_sq) + SUM_W'(new_sq);
						pos_q <= (32'(pos_use) + 1 >= 32'(len_eff)) ? '0 : pos_use + AW'(1);
					end
					div_for_mean_q <= 1'b0;
					if (dcount_n >= ratio_eff) begin
						point_q <= 1'b1;
						dsum_q <= dsum_n;
						dpeak_q <= dpeak_n;
						dcount_q <= dcount_n;
					end else begin
						point_q <= 1'b0;
						dsum_q <= dsum_n;
						dpeak_q <= dpeak_n;
						dcount_q <= dcount_n;
					end
				end
				ST_DIV: if (drsp.done) sq_cnt_q <= 5'd20;
				ST_SQRT: begin
					if (sq_cnt_q == 5'd0) rms_q <= MAG_W'(
						(sq_x_q >= sq_rb) ? ((sq_r_q >> 1) + sq_bit) : (sq_r_q >> 1));
					else sq_cnt_q <= sq_cnt_q - 5'd1;
				end
				ST_MEAN: if (point_q && !div_for_mean_q) div_for_mean_q <= 1'b1;
				ST_OUT: begin
					if (out_go) begin
						out_valid_q <= 1'b1;
						if (point_q) begin
							dsum_q <= '0;
							dpeak_q <= '0;
							dcount_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) mag_q <= mag_c;
		if (state_q == ST_DIV && drsp.done) begin
			sq_x_q <= drsp.quotient;
			sq_r_q <= '0;
		end else if (state_q == ST_SQRT && sq_cnt_q != 5'd0) begin
			if (sq_x_q >= sq_rb) begin
				sq_x_q <= sq_x_q - sq_rb;
				sq_r_q <= (sq_r_q >> 1) + sq_bit;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
		end
		if (state_q == ST_MEAN && div_for_mean_q && drsp.done)
			pmean_q <= drsp.quotient[MAG_W-1:0];
	end

	always_comb begin
		out_q.max_amplitude = rmax_q;
		out_q.rms_level = rms_q;
		out_q.point_valid = point_q;
		out_q.point_mean = point_q ? pmean_q : '0;
		out_q.point_peak = (point_q && peak_en_q) ? dpeak_q : '0;
		out_q.point_rms = (point_q && rms_en_q) ? rms_q : '0;
		out_q.frames_seen = frames_q;
	end

	// result holds until taken: mean, peak and count clear only once it is emitted
	result_t hold_q;
	always_ff @(posedge clk) begin
		if (out_go) hold_q <= out_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {7'd0, hold_q.frames_seen, hold_q.point_rms, hold_q.point_peak,
		hold_q.point_mean, hold_q.point_valid, hold_q.rms_level, hold_q.max_amplitude};

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n) in_acc |=> state_q == ST_READ;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy) else $error("bad accept");

	property p_out_after_out;
		@(posedge clk) disable iff (!arst_n) out_go |=> m_tvalid;
	endproperty
	a_out_after_out: assert property (p_out_after_out) else $error("word lost");

	property p_no_ready_clear;
		@(posedge clk) disable iff (!arst_n) state_q == ST_CLEAR |-> !s_tready;
	endproperty
	a_no_ready_clear: assert property (p_no_ready_clear) else $error("ready in clear");

endmodule

>>> bench/audio_peak_rms_decimator_tb.sv
// testbench for the audio peak / rms decimator: scoreboard predictor, random frames, checks
`timescale 1ns / 100ps

module audio_peak_rms_decimator_tb;
	import aprd_pkg::*;

	typedef struct {
		logic [15:0] max_amp;
		logic [15:0] rms_lvl;
		logic        pt_valid;
		logic [15:0] pt_mean;
		logic [15:0] pt_peak;
		logic [15:0] pt_rms;
		logic [47:0] frames;
	} envelope_word_t;

	class envelope_scoreboard;
		logic [3:0]        chans;
		logic [12:0]       ratio;
		logic [12:0]       wlen;
		bit                peak_en;
		bit                rms_en;
		int unsigned       sq_ring[4096];
		longint unsigned   sq_total;
		int unsigned       ring_pos;
		longint unsigned   dec_total;
		int unsigned       dec_peak;
		int unsigned       dec_cnt;
		int unsigned       run_max;
		int unsigned       rms_now;
		longint unsigned   frames;
		envelope_word_t    pending_words[$];
		int unsigned       errors;

		function new();
			chans = 1;
			ratio = 64;
			wlen = 1024;
			peak_en = 1;
			rms_en = 1;
			clear_ring();
			clear_point();
			run_max = 0;
			rms_now = 0;
			frames = 0;
			errors = 0;
		endfunction

		function void clear_ring();
			for (int i = 0; i < 4096; i++) sq_ring[i] = 0;
			sq_total = 0;
			ring_pos = 0;
		endfunction

		function void clear_point();
			dec_total = 0;
			dec_peak = 0;
			dec_cnt = 0;
		endfunction

		function int unsigned limit(int unsigned v, int unsigned hi);
			if (v == 0) return 1;
			return (v > hi) ? hi : v;
		endfunction

		function int unsigned floor_root(longint unsigned x);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return int'(r);
		endfunction

		function void write_reg(logic [2:0] idx, logic [12:0] val);
			case (idx)
				REG_NUM_CHANNELS: chans = val[3:0];
				REG_DECIMATION_RATIO: begin
					ratio = val;
					clear_point();
				end
				REG_RMS_WINDOW_LENGTH: begin
					wlen = val;
					clear_ring();
				end
				REG_PEAK_ENABLE: peak_en = val[0];
				REG_RMS_ENABLE: rms_en = val[0];
				default: ;
			endcase
		endfunction

		function void note_frame(logic [IN_WIDTH-1:0] d);
			int unsigned n, rat, len, pos, mag;
			int acc, mono;
			logic signed [15:0] s;
			envelope_word_t w;
			n = limit(chans, 8);
			rat = limit(ratio, 4096);
			len = limit(wlen, 4096);
			acc = 0;
			for (int i = 0; i < n; i++) begin
				s = d[16*i +: 16];
				acc += s;
			end
			mono = acc / int'(n);
			mag = (mono < 0) ? -mono : mono;
			if (mag > run_max) run_max = mag;
			if (rms_en) begin
				pos = (ring_pos < len) ? ring_pos : 0;
				sq_total = sq_total - longint'(sq_ring[pos]) * sq_ring[pos]
					+ longint'(mag) * mag;
				sq_ring[pos] = mag;
				ring_pos = (pos + 1) % len;
				rms_now = floor_root(sq_total / len);
			end
			dec_total += mag;
			if (mag > dec_peak) dec_peak = mag;
			dec_cnt++;
			w.pt_valid = 0;
			w.pt_mean = 0;
			w.pt_peak = 0;
			w.pt_rms = 0;
			if (dec_cnt >= rat) begin
				w.pt_valid = 1;
				w.pt_mean = dec_total / dec_cnt;
				w.pt_peak = peak_en ? dec_peak : 0;
				w.pt_rms = rms_en ? rms_now : 0;
				clear_point();
			end
			if (frames < 48'hFFFF_FFFF_FFFF) frames++;
			w.max_amp = run_max;
			w.rms_lvl = rms_now;
			w.frames = frames;
			pending_words.insert(pending_words.size(), w);
		endfunction

		task flag(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_word(logic [OUT_WIDTH-1:0] d);
			envelope_word_t e;
			if (pending_words.size() == 0) begin
				flag("result word with nothing expected");
				return;
			end
			e = pending_words[0];
			pending_words.delete(0);
			if (d[15:0] !== e.max_amp)
				flag($sformatf("max_amplitude %0d exp %0d", d[15:0], e.max_amp));
			if (d[31:16] !== e.rms_lvl)
				flag($sformatf("rms_level %0d exp %0d", d[31:16], e.rms_lvl));
			if (d[32] !== e.pt_valid)
				flag($sformatf("point_valid %0b exp %0b", d[32], e.pt_valid));
			if (d[48:33] !== e.pt_mean)
				flag($sformatf("point_mean %0d exp %0d", d[48:33], e.pt_mean));
			if (d[64:49] !== e.pt_peak)
				flag($sformatf("point_peak %0d exp %0d", d[64:49], e.pt_peak));
			if (d[80:65] !== e.pt_rms)
				flag($sformatf("point_rms %0d exp %0d", d[80:65], e.pt_rms));
			if (d[128:81] !== e.frames)
				flag($sformatf("frames_seen %0d exp %0d", d[128:81], e.frames));
		endtask
	endclass

	logic                     clk = 0;
	logic                     arst_n = 0;
	logic                     cfg_we = 0;
	logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_WIDTH-1:0]     cfg_data = '0;
	logic                     s_tvalid = 0;
	logic                     s_tready;
	logic [IN_WIDTH-1:0]      s_tdata = '0;
	logic                     m_tvalid;
	logic                     m_tready = 0;
	logic [OUT_WIDTH-1:0]     m_tdata;
	bit                       quiet = 0;
	bit                       hold_go = 0;
	envelope_scoreboard       sb;

	audio_peak_rms_decimator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	initial sb = new();

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_word(m_tdata);
	end

	// receiver side, with one long hold-off on request
	always begin
		@(posedge clk);
		if (hold_go) begin
			hold_go = 0;
			repeat (3000) begin
				m_tready <= 0;
				@(posedge clk);
			end
		end
		m_tready <= quiet || ($urandom_range(0, 99) >= 38);
	end

	initial begin
		#20_000_000;
		$display("audio_peak_rms_decimator_tb NOT OK");
		$finish;
	end

	task automatic write_reg(logic [2:0] idx, logic [12:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
	endtask

	task automatic send_frame(logic [IN_WIDTH-1:0] d);
		while (!quiet && $urandom_range(0, 99) < 38) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_frame(d);
	endtask

	task automatic drain();
		@(posedge clk);
		s_tvalid <= 0;
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_all(logic [12:0] nch, logic [12:0] rat, logic [12:0] len,
			logic [12:0] pk, logic [12:0] rm);
		write_reg(REG_NUM_CHANNELS, nch);
		write_reg(REG_DECIMATION_RATIO, rat);
		write_reg(REG_RMS_WINDOW_LENGTH, len);
		write_reg(REG_PEAK_ENABLE, pk);
		write_reg(REG_RMS_ENABLE, rm);
	endtask

	function automatic logic [IN_WIDTH-1:0] same_frame(logic [15:0] v);
		return {8{v}};
	endfunction

	function automatic logic [IN_WIDTH-1:0] rand_frame();
		logic [IN_WIDTH-1:0] d;
		logic [15:0] v;
		v = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			for (int i = 0; i < 8; i++) d[16*i +: 16] = v + 16'($urandom_range(0, 31));
			return d;
		end
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 9))
				0: d[16*i +: 16] = 16'h8000;
				1: d[16*i +: 16] = 16'h7fff;
				2: d[16*i +: 16] = 16'h0000;
				3: d[16*i +: 16] = 16'($signed($urandom_range(0, 64)) - 32);
				default: d[16*i +: 16] = $urandom;
			endcase
		end
		return d;
	endfunction

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) send_frame(rand_frame());
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// reset settings first
		send_frame(same_frame(16'h8000));
		send_frame(same_frame(16'h7fff));
		send_frame(same_frame(16'h0000));
		send_frame(same_frame(16'hffff));
		drain();

		set_all(8, 1, 1, 1, 1);
		send_frame(same_frame(16'h8000));
		send_frame(same_frame(16'h7fff));
		send_frame({16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
			16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
		send_frame({8{16'h0001}} ^ {16'h0000, {7{16'h0002}}});
		send_frame(same_frame(16'h5555));
		send_frame(same_frame(16'haaaa));
		drain();

		// channel count, ratio and window length of zero and beyond range
		set_all(0, 0, 0, 0, 1);
		send_frame({{7{16'h7fff}}, 16'h8001});
		send_frame(same_frame(16'h1234));
		drain();
		set_all(15, 8191, 8191, 1, 0);
		send_frame(same_frame(16'h8000));
		send_frame(same_frame(16'h0fff));
		drain();
		for (int i = NUM_REGS; i < 8; i++) write_reg(3'(i), 13'h1fff);
		send_frame(same_frame(16'hc000));
		send_frame(same_frame(16'h4000));
		drain();

		set_all(3, 5, 7, 1, 1);
		run_random(110);

		set_all(8, 1, 1, 0, 1);
		quiet = 1;
		hold_go = 1;
		run_random(60);
		quiet = 0;

		set_all(1, 4096, 4096, 1, 1);
		run_random(70);

		set_all(2, 13, 4096, 1, 1);
		run_random(90);

		set_all(6, 3, 2, 1, 0);
		run_random(60);

		set_all(4, 7, 16, 1, 1);
		run_random(60);
		write_reg(REG_RMS_ENABLE, 0);
		run_random(20);
		write_reg(REG_RMS_ENABLE, 1);
		write_reg(REG_DECIMATION_RATIO, 2);
		run_random(40);
		write_reg(REG_NUM_CHANNELS, 5);
		run_random(40);

		if (sb.errors == 0) begin
			$display("audio_peak_rms_decimator_tb OK");
		end else begin
			$display("audio_peak_rms_decimator_tb NOT OK");
		end
		$finish;
	end
endmodule
